>>> src/ap2c_pkg.sv
package ap2c_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int FRAC_BITS  = 16;
    localparam int SLOT_W     = 10;
    localparam int FRAC_W     = 16;
    localparam int WIDTH_W    = 17;
    localparam int SIZE_W     = 11;
    localparam int LOAD_W     = 32;
    localparam int SCALED_W   = FRAC_BITS + SLOT_W + 2;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [FRAC_W-1:0]   frac_t;
    typedef logic [WIDTH_W-1:0]  width_t;
    typedef logic [SIZE_W-1:0]   size_t;
    typedef logic [LOAD_W-1:0]   load_t;
    typedef logic [SCALED_W-1:0] scaled_t;
    typedef logic [1:0]          cfg_idx_t;

    localparam width_t ONE_FX = width_t'(1) << FRAC_BITS;

    localparam cfg_idx_t REG_OFFSET = 2'd0;
    localparam cfg_idx_t REG_WIDTH  = 2'd1;
    localparam cfg_idx_t REG_SIZE   = 2'd2;

    localparam logic REQ_PICK   = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

endpackage

>>> src/ap2c_if.sv
interface ap2c_req_if;
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    ap2c_pkg::frac_t       rand_first;
    ap2c_pkg::frac_t       rand_second;
    ap2c_pkg::slot_t       slot_index;
    ap2c_pkg::load_t       load_value;

    modport source
    (
        output valid, req_type, rand_first, rand_second, slot_index, load_value,
        input  ready
    );

    modport sink
    (
        input  valid, req_type, rand_first, rand_second, slot_index, load_value,
        output ready
    );
endinterface

interface ap2c_rsp_if;
    logic                  valid;
    logic                  ready;
    ap2c_pkg::slot_t       first_slot;
    ap2c_pkg::slot_t       second_slot;
    ap2c_pkg::slot_t       chosen_slot;
    logic                  same_pick;

    modport source
    (
        output valid, first_slot, second_slot, chosen_slot, same_pick,
        input  ready
    );

    modport sink
    (
        input  valid, first_slot, second_slot, chosen_slot, same_pick,
        output ready
    );
endinterface

>>> src/aperture_power_of_two_choice_core.sv
// Power-of-two-choices slot picker confined to an aperture window of the ring.
// The request channel carries pick and load-update transactions; the response
// channel carries one transaction per pick and nothing for an update. The window
// offset, window width and ring size are written through the APB port; the user
// must write them only while the block is idle, as the block does not enforce it.
// An update writes the load table in the cycle it is accepted.
// A pick passes through nine steps of a single sequencer from acceptance to its
// response being presented (two multiplies for the first slot, window overlap and
// remainder arithmetic, the second multiply and wrap, one step for the two reads
// of the load table and one for the compare). One pick is in flight at a time, so
// a new request is accepted only after the last pick's compare step.
// After reset the load table is cleared, one entry per cycle, through all 1024 entries;
// no request transaction is accepted meanwhile, but configuration writes are.
// The response sits in an output register, so a new request is accepted while a
// response waits; if the receiver stalls, the next pick waits at its compare step.
module aperture_power_of_two_choice_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ap2c_pkg::PADDR_W-1:0]      paddr,
    input  logic [ap2c_pkg::PDATA_W-1:0]      pwdata,
    output logic [ap2c_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    ap2c_req_if.sink                          req,
    ap2c_rsp_if.source                        rsp
);

    typedef enum logic [9:0]
    {
        ST_CLEAR = 10'b00_0000_0001,
        ST_IDLE  = 10'b00_0000_0010,
        ST_P1    = 10'b00_0000_0100,
        ST_FIRST = 10'b00_0000_1000,
        ST_WIN   = 10'b00_0001_0000,
        ST_OV    = 10'b00_0010_0000,
        ST_REM   = 10'b00_0100_0000,
        ST_MUL   = 10'b00_1000_0000,
        ST_ADJ   = 10'b01_0000_0000,
        ST_READ  = 10'b10_0000_0000
    } state_t;

    localparam int FB = ap2c_pkg::FRAC_BITS;

    state_t state_reg, state_next;
    logic   cmp_reg, cmp_next;

    ap2c_pkg::frac_t   off_reg;
    ap2c_pkg::width_t  wid_reg;
    ap2c_pkg::size_t   size_reg;
    ap2c_pkg::slot_t   clr_reg;

    ap2c_pkg::size_t   s_eff;
    ap2c_pkg::width_t  wid_eff;
    ap2c_pkg::scaled_t full;

    ap2c_pkg::frac_t   r1_reg, r2_reg, p1_reg;
    ap2c_pkg::slot_t   first_reg, second_reg;
    ap2c_pkg::scaled_t o_reg, ws_reg, b_reg, ewin_reg, e_reg, rem_reg, thr_reg, p_reg;
    ap2c_pkg::width_t  ov_reg;
    logic              rem_zero_reg;
    ap2c_pkg::load_t   lda_reg, ldb_reg;

    logic [2*FB:0]                  prod1;
    logic [FB:0]                    p1sum;
    logic [FB+ap2c_pkg::SIZE_W-1:0] prodf;
    logic [FB+ap2c_pkg::SCALED_W-1:0] prod2;
    ap2c_pkg::scaled_t b0, bf, e_c, hi, lo, pw;
    ap2c_pkg::slot_t   sec_c;

    ap2c_pkg::load_t   mem [ap2c_pkg::RING_DEPTH];
    logic              mem_we;
    ap2c_pkg::slot_t   mem_waddr;
    ap2c_pkg::load_t   mem_wdata;

    logic              out_valid_reg, out_valid_next;
    ap2c_pkg::slot_t   out_first_reg, out_second_reg, out_chosen_reg;
    logic              out_same_reg;
    logic              out_free;
    logic              cfg_we;
    ap2c_pkg::cfg_idx_t cfg_idx;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg  <= '0;
            wid_reg  <= ap2c_pkg::ONE_FX;
            size_reg <= ap2c_pkg::size_t'(ap2c_pkg::RING_DEPTH);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                ap2c_pkg::REG_OFFSET: off_reg  <= pwdata[ap2c_pkg::FRAC_W-1:0];
                ap2c_pkg::REG_WIDTH:  wid_reg  <= pwdata[ap2c_pkg::WIDTH_W-1:0];
                ap2c_pkg::REG_SIZE:   size_reg <= pwdata[ap2c_pkg::SIZE_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            ap2c_pkg::REG_OFFSET: prdata = ap2c_pkg::PDATA_W'(off_reg);
            ap2c_pkg::REG_WIDTH:  prdata = ap2c_pkg::PDATA_W'(wid_reg);
            ap2c_pkg::REG_SIZE:   prdata = ap2c_pkg::PDATA_W'(size_reg);
            default:              prdata = '0;
        endcase
    end

    // Clamped configuration.
    always_comb
    begin
        if (size_reg == '0)
            s_eff = ap2c_pkg::size_t'(1);
        else if (size_reg > ap2c_pkg::size_t'(ap2c_pkg::RING_DEPTH))
            s_eff = ap2c_pkg::size_t'(ap2c_pkg::RING_DEPTH);
        else
            s_eff = size_reg;
        wid_eff = (wid_reg > ap2c_pkg::ONE_FX) ? ap2c_pkg::ONE_FX : wid_reg;
        full    = ap2c_pkg::scaled_t'(s_eff) << FB;
    end

    // Datapath arithmetic, one step per sequencer state.
    always_comb
    begin
        prod1 = (2*FB+1)'(r1_reg) * (2*FB+1)'(wid_eff);
        p1sum = (FB+1)'(off_reg) + prod1[2*FB:FB];
        prodf = (FB+ap2c_pkg::SIZE_W)'(p1_reg) * (FB+ap2c_pkg::SIZE_W)'(s_eff);
        b0    = ap2c_pkg::scaled_t'(first_reg) << FB;
        bf    = b0 + full;
        e_c   = b_reg + ap2c_pkg::scaled_t'(ap2c_pkg::ONE_FX);
        hi    = (e_c < ewin_reg) ? e_c : ewin_reg;
        lo    = (b_reg > o_reg) ? b_reg : o_reg;
        prod2 = (FB+ap2c_pkg::SCALED_W)'(r2_reg) * (FB+ap2c_pkg::SCALED_W)'(rem_reg);
        pw    = (p_reg >= full) ? (p_reg - full) : p_reg;
        sec_c = rem_zero_reg ? first_reg : ap2c_pkg::slot_t'(pw >> FB);
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                r1_reg <= req.rand_first;
                r2_reg <= req.rand_second;
            end
            ST_P1:
            begin
                p1_reg <= (p1sum >= ap2c_pkg::ONE_FX) ?
                          ap2c_pkg::frac_t'(p1sum - ap2c_pkg::ONE_FX) :
                          ap2c_pkg::frac_t'(p1sum);
                o_reg  <= ap2c_pkg::scaled_t'(off_reg) * ap2c_pkg::scaled_t'(s_eff);
                ws_reg <= ap2c_pkg::scaled_t'(wid_eff) * ap2c_pkg::scaled_t'(s_eff);
            end
            ST_FIRST:
                first_reg <= ap2c_pkg::slot_t'(prodf >> FB);
            ST_WIN:
            begin
                ewin_reg <= o_reg + ws_reg;
                b_reg    <= (bf < o_reg + ws_reg) ? bf : b0;
            end
            ST_OV:
            begin
                e_reg  <= e_c;
                ov_reg <= (hi > lo) ? ap2c_pkg::width_t'(hi - lo) : '0;
            end
            ST_REM:
            begin
                rem_reg      <= ws_reg - ap2c_pkg::scaled_t'(ov_reg);
                thr_reg      <= e_reg - ap2c_pkg::scaled_t'(ov_reg);
                rem_zero_reg <= (ws_reg == ap2c_pkg::scaled_t'(ov_reg));
            end
            ST_MUL:
                p_reg <= o_reg + ap2c_pkg::scaled_t'(prod2 >> FB);
            ST_ADJ:
                p_reg <= (p_reg >= thr_reg) ? (p_reg + ap2c_pkg::scaled_t'(ov_reg)) : p_reg;
            ST_READ:
                second_reg <= sec_c;
            default:
                ;
        endcase
    end

    // Load table: one write port, two registered read ports.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = req.slot_index;
        mem_wdata = req.load_value;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if (req.valid && req.ready && req.req_type == ap2c_pkg::REQ_UPDATE)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (state_reg == ST_READ)
        begin
            lda_reg <= mem[first_reg];
            ldb_reg <= mem[sec_c];
        end
    end

    // Sequencer.
    assign req.ready = (state_reg == ST_IDLE) && !cmp_reg;
    assign out_free  = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next     = state_reg;
        cmp_next       = cmp_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == ap2c_pkg::slot_t'(ap2c_pkg::RING_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (cmp_reg)
                begin
                    if (out_free)
                    begin
                        cmp_next       = 1'b0;
                        out_valid_next = 1'b1;
                    end
                end
                else if (req.valid && req.req_type == ap2c_pkg::REQ_PICK)
                    state_next = ST_P1;
            end
            ST_P1:    state_next = ST_FIRST;
            ST_FIRST: state_next = ST_WIN;
            ST_WIN:   state_next = ST_OV;
            ST_OV:    state_next = ST_REM;
            ST_REM:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_ADJ;
            ST_ADJ:   state_next = ST_READ;
            ST_READ:
            begin
                state_next = ST_IDLE;
                cmp_next   = 1'b1;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cmp_reg       <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_reg       <= cmp_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + ap2c_pkg::slot_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_reg && out_free)
        begin
            out_first_reg  <= first_reg;
            out_second_reg <= second_reg;
            out_chosen_reg <= (lda_reg < ldb_reg) ? first_reg : second_reg;
            out_same_reg   <= (first_reg == second_reg);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.first_slot  = out_first_reg;
    assign rsp.second_slot = out_second_reg;
    assign rsp.chosen_slot = out_chosen_reg;
    assign rsp.same_pick   = out_same_reg;

    // The chosen slot is always one of the two picks.
    a_chosen_is_pick: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.chosen_slot == rsp.first_slot ||
                       rsp.chosen_slot == rsp.second_slot))
        else $error("chosen slot is neither pick");

    // The same-pick flag agrees with the two slots.
    a_same_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.same_pick == (rsp.first_slot == rsp.second_slot)))
        else $error("same_pick flag disagrees with slots");

    // An empty remainder leaves the second pick on the first slot.
    a_empty_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && rem_zero_reg) |=> (second_reg == first_reg))
        else $error("empty remainder gave a different second slot");

    // No request is taken while the load table is being cleared or a pick is in flight.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE || cmp_reg) |-> !req.ready)
        else $error("request accepted while busy");

    // The clearing pass ends after the last entry.
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR &&
         clr_reg == ap2c_pkg::slot_t'(ap2c_pkg::RING_DEPTH - 1)) |=> (state_reg == ST_IDLE))
        else $error("clearing pass did not finish");

endmodule
